// ===== src/slab_pkg.sv =====
// Package for the sRGB to CIELAB converter: widths, defaults, linearization table function.
`default_nettype none
package slab_pkg;
    localparam int DEF_OUT_FRAC_BITS      = 6;
    localparam int DEF_INTERNAL_FRAC_BITS = 16;
    localparam int LIGHT_WIDTH            = 13;
    localparam int CHROMA_WIDTH           = 14;
    localparam int CHAN_WIDTH             = 8;

    function automatic logic [63:0] mul30(input logic [63:0] p, input logic [63:0] q);
        return (p * q + (64'd1 << 29)) >> 30;
    endfunction

    function automatic logic [63:0] pow5_q30(input logic [63:0] y);
        logic [63:0] y2;
        logic [63:0] y4;
        y2 = mul30(y, y);
        y4 = mul30(y2, y2);
        return mul30(y4, y);
    endfunction

    // Linear-light value of one 8-bit code, Q(w); evaluated at elaboration only.
    function automatic logic [63:0] lin_entry(input int c, input int w);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] lin;
        int          s;
        s = 30 - w;
        if (c * 100000 > 4045 * 255) begin
            u  = ((64'(1000 * c + 14025) << 30) + 64'd134512) / 64'd269025;
            u2 = mul30(u, u);
            lo = 64'd0;
            hi = 64'd1 << 30;
            while (lo < hi) begin
                mid = lo + (hi - lo + 64'd1) / 64'd2;
                if (pow5_q30(mid) <= u2) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
            lin = mul30(u2, lo);
            return (lin + (64'd1 << (s - 1))) >> s;
        end
        return ((64'(c * 100) << w) + 64'd164730) / 64'd329460;
    endfunction
endpackage
`default_nettype wire

// ===== src/slab_cdiv.sv =====
// Pipelined divide by a constant: reciprocal multiply, then one-step correction.
`default_nettype none
module slab_cdiv #(
    parameter int     NW  = 34,
    parameter int     QW  = 18,
    parameter longint DIV = 3
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire logic [NW-1:0] i_num,
    output logic               o_vld,
    output logic [QW-1:0]      o_quo
);
    localparam int          PW      = 2 * NW + 1;
    localparam logic [63:0] RECIP64 = (64'd1 << NW) / 64'(DIV);
    localparam logic [NW:0] RECIP   = RECIP64[NW:0];
    localparam logic [NW-1:0] DIVW  = NW'(DIV);

    logic [PW-1:0] r_prod;
    logic [NW-1:0] r_num;
    logic [NW-1:0] r_qe;
    logic [NW-1:0] r_rem;
    logic [QW-1:0] r_quo;
    logic          r_v1;
    logic          r_v2;
    logic          r_v3;
    logic [NW-1:0] q_est;
    logic [NW-1:0] n_rem;

    // estimate is exact or one low
    assign q_est = r_prod[2*NW-1:NW];
    assign n_rem = r_num - NW'(q_est * DIVW);

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_num) * PW'(RECIP);
        r_num  <= i_num;
        r_qe   <= q_est;
        r_rem  <= n_rem;
        r_quo  <= (r_rem >= DIVW) ? QW'(r_qe + NW'(1)) : QW'(r_qe);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_vld = r_v3;
    assign o_quo = r_quo;
endmodule
`default_nettype wire

// ===== src/slab_cbrt.sv =====
// CIELAB f(t): bitwise cube root pipeline beside the linear segment.
`default_nettype none
module slab_cbrt #(
    parameter int W = slab_pkg::DEF_INTERNAL_FRAC_BITS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_vld,
    input  wire logic [W+1:0]   i_t,
    output logic                o_vld,
    output logic [W+1:0]        o_f
);
    localparam int TW   = W + 2;
    localparam int NB   = W + 2;
    localparam int SQW  = TW + 2;
    localparam int CBW  = SQW + TW - W;
    localparam int MW   = TW + 20;
    localparam int LNW  = W + 23;
    localparam int DLY  = 2 * NB - 3;
    localparam int FLY  = 2 * NB;
    localparam logic [TW-1:0] LIMIT = TW'(64'd1 << (W + 1));
    localparam logic [MW-1:0] THR   = MW'(64'd8856 << W);

    logic [TW-1:0]  r_t0;
    logic           r_root0;
    logic           r_v0;
    logic [LNW-1:0] r_lnum;
    logic [MW-1:0]  t_scaled;

    logic [TW-1:0]  y_in [NB+1];
    logic [TW-1:0]  t_in [NB+1];
    logic [TW-1:0]  r_cand [NB];
    logic [SQW-1:0] r_sq [NB];
    logic [TW-1:0]  r_yb [NB];
    logic [TW-1:0]  r_tb [NB];
    logic [TW-1:0]  r_ya [NB];
    logic [TW-1:0]  r_ta [NB];

    logic [TW-1:0]  lin_q;
    logic [TW-1:0]  r_ld [DLY];
    logic           r_fl [FLY];
    logic           r_vl [FLY];
    logic [TW-1:0]  r_f;
    logic           r_fv;

    assign t_scaled = MW'(i_t) * MW'(1000000);

    always_ff @(posedge i_clk) begin
        r_t0    <= i_t;
        r_root0 <= t_scaled > THR;
        r_lnum  <= LNW'(i_t) * LNW'(903292) + LNW'(64'd16000 << W) + LNW'(58000);
    end

    assign y_in[0] = '0;
    assign t_in[0] = r_t0;

    // one result bit per stage pair, most significant first
    for (genvar k = 0; k < NB; k++) begin : g_bit
        logic [TW-1:0]     cand;
        logic [2*TW-1:0]   sq_full;
        logic [SQW+TW-1:0] cube_full;
        logic [CBW-1:0]    cube;
        logic              keep;
        assign cand      = y_in[k] | (TW'(1) << (NB - 1 - k));
        assign sq_full   = (2*TW)'(cand) * (2*TW)'(cand);
        assign cube_full = (SQW+TW)'(r_sq[k]) * (SQW+TW)'(r_cand[k]);
        assign cube      = cube_full[SQW+TW-1:W];
        assign keep      = (r_cand[k] <= LIMIT) && (cube <= CBW'(r_tb[k]));
        always_ff @(posedge i_clk) begin
            r_cand[k] <= cand;
            r_sq[k]   <= SQW'(sq_full >> W);
            r_yb[k]   <= y_in[k];
            r_tb[k]   <= t_in[k];
            r_ya[k]   <= keep ? r_cand[k] : r_yb[k];
            r_ta[k]   <= r_tb[k];
        end
        assign y_in[k+1] = r_ya[k];
        assign t_in[k+1] = r_ta[k];
    end

    slab_cdiv #(.NW(LNW), .QW(TW), .DIV(116000)) u_lin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_v0),
        .i_num   (r_lnum),
        .o_vld   (),
        .o_quo   (lin_q)
    );

    always_ff @(posedge i_clk) begin
        r_ld[0] <= lin_q;
        for (int i = 1; i < DLY; i++) begin
            r_ld[i] <= r_ld[i-1];
        end
        r_fl[0] <= r_root0;
        for (int i = 1; i < FLY; i++) begin
            r_fl[i] <= r_fl[i-1];
        end
        r_f <= r_fl[FLY-1] ? y_in[NB] : r_ld[DLY-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            for (int i = 0; i < FLY; i++) begin
                r_vl[i] <= 1'b0;
            end
            r_fv <= 1'b0;
        end else begin
            r_v0    <= i_vld;
            r_vl[0] <= r_v0;
            for (int i = 1; i < FLY; i++) begin
                r_vl[i] <= r_vl[i-1];
            end
            r_fv <= r_vl[FLY-1];
        end
    end

    assign o_vld = r_fv;
    assign o_f   = r_f;
endmodule
`default_nettype wire

// ===== src/srgb_to_cielab.sv =====
// sRGB to CIELAB (D65) converter, top level.
// One pixel is taken every clock and busy never rises. Each item's L, a and b
// appear for one cycle with o_strobe, after the dividers, the cube-root
// pipeline (one result bit per two stages) and the scaling and clamping
// registers. Results cannot be held off, so the receiver must take each one
// in its strobe cycle. Outputs carry OUT_FRAC_BITS fraction bits; a and b
// saturate to the 14-bit range.
`default_nettype none
module srgb_to_cielab #(
    parameter int OUT_FRAC_BITS      = slab_pkg::DEF_OUT_FRAC_BITS,
    parameter int INTERNAL_FRAC_BITS = slab_pkg::DEF_INTERNAL_FRAC_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  i_red_in,
    input  wire logic [7:0]  i_green_in,
    input  wire logic [7:0]  i_blue_in,
    output logic             o_strobe,
    output logic [slab_pkg::LIGHT_WIDTH-1:0]  o_lightness,
    output logic [slab_pkg::CHROMA_WIDTH-1:0] o_green_red,
    output logic [slab_pkg::CHROMA_WIDTH-1:0] o_blue_yellow
);
    localparam int W   = INTERNAL_FRAC_BITS;
    localparam int LW  = W + 1;
    localparam int NW  = W + 18;
    localparam int TW  = W + 2;
    localparam int SW  = W + 13;
    localparam int S   = W - OUT_FRAC_BITS;
    localparam int LAT = 2 * (W + 2) + 10;
    localparam int CW  = slab_pkg::CHROMA_WIDTH;
    localparam int LTW = slab_pkg::LIGHT_WIDTH;
    localparam longint LMAX_A = 64'd100 << OUT_FRAC_BITS;
    localparam longint LMAX_B = (64'd1 << LTW) - 1;
    localparam logic signed [SW-1:0] LMAX = SW'((LMAX_A < LMAX_B) ? LMAX_A : LMAX_B);
    localparam logic signed [SW-1:0] CMAX = SW'((64'd1 << (CW - 1)) - 1);
    localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);
    localparam logic [SW-1:0] HALF = SW'(64'd1 << (S - 1));

    logic [LW-1:0] lin_rom [256];
    for (genvar gi = 0; gi < 256; gi++) begin : g_rom
        assign lin_rom[gi] = LW'(slab_pkg::lin_entry(gi, W));
    end

    logic [7:0]    r_r;
    logic [7:0]    r_g;
    logic [7:0]    r_b;
    logic          r_v1;
    logic [LW-1:0] r_lr;
    logic [LW-1:0] r_lg;
    logic [LW-1:0] r_lb;
    logic          r_v2;
    logic [NW-1:0] r_nx;
    logic [NW-1:0] r_ny;
    logic [NW-1:0] r_nz;
    logic          r_v3;
    logic [TW-1:0] x_q;
    logic [TW-1:0] y_q;
    logic [TW-1:0] z_q;
    logic          xyz_v;
    logic [TW-1:0] fx;
    logic [TW-1:0] fy;
    logic [TW-1:0] fz;
    logic          f_v;
    logic signed [SW-1:0] r_lraw;
    logic signed [SW-1:0] r_araw;
    logic signed [SW-1:0] r_braw;
    logic          r_v4;
    logic signed [SW-1:0] l_rnd;
    logic signed [SW-1:0] a_rnd;
    logic signed [SW-1:0] b_rnd;
    logic [LTW-1:0] r_l;
    logic [CW-1:0]  r_a;
    logic [CW-1:0]  r_bb;
    logic           r_v5;

    function automatic logic signed [SW-1:0] rnd(input logic signed [SW-1:0] v);
        logic [SW-1:0] mag;
        logic [SW-1:0] m;
        mag = v[SW-1] ? SW'(-v) : SW'(v);
        m   = (mag + HALF) >> S;
        return v[SW-1] ? -$signed(m) : $signed(m);
    endfunction

    always_ff @(posedge i_clk) begin
        r_r  <= i_red_in;
        r_g  <= i_green_in;
        r_b  <= i_blue_in;
        r_lr <= lin_rom[r_r];
        r_lg <= lin_rom[r_g];
        r_lb <= lin_rom[r_b];
        r_nx <= NW'(10) * (NW'(4124) * NW'(r_lr) + NW'(3576) * NW'(r_lg)
                + NW'(1805) * NW'(r_lb)) + NW'(47523);
        r_ny <= NW'(2126) * NW'(r_lr) + NW'(7152) * NW'(r_lg)
                + NW'(722) * NW'(r_lb) + NW'(5000);
        r_nz <= NW'(10) * (NW'(193) * NW'(r_lr) + NW'(1192) * NW'(r_lg)
                + NW'(9505) * NW'(r_lb)) + NW'(54441);
    end

    slab_cdiv #(.NW(NW), .QW(TW), .DIV(95047)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v3), .i_num(r_nx),
        .o_vld(xyz_v), .o_quo(x_q)
    );
    slab_cdiv #(.NW(NW), .QW(TW), .DIV(10000)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v3), .i_num(r_ny),
        .o_vld(), .o_quo(y_q)
    );
    slab_cdiv #(.NW(NW), .QW(TW), .DIV(108883)) u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v3), .i_num(r_nz),
        .o_vld(), .o_quo(z_q)
    );

    slab_cbrt #(.W(W)) u_f_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(xyz_v), .i_t(x_q),
        .o_vld(f_v), .o_f(fx)
    );
    slab_cbrt #(.W(W)) u_f_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(xyz_v), .i_t(y_q),
        .o_vld(), .o_f(fy)
    );
    slab_cbrt #(.W(W)) u_f_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(xyz_v), .i_t(z_q),
        .o_vld(), .o_f(fz)
    );

    always_ff @(posedge i_clk) begin
        r_lraw <= SW'(116) * $signed(SW'(fy)) - $signed(SW'(64'd16 << W));
        r_araw <= SW'(500) * ($signed(SW'(fx)) - $signed(SW'(fy)));
        r_braw <= SW'(200) * ($signed(SW'(fy)) - $signed(SW'(fz)));
    end

    assign l_rnd = rnd(r_lraw);
    assign a_rnd = rnd(r_araw);
    assign b_rnd = rnd(r_braw);

    always_ff @(posedge i_clk) begin
        if (l_rnd < 0) begin
            r_l <= '0;
        end else if (l_rnd > LMAX) begin
            r_l <= LTW'(LMAX);
        end else begin
            r_l <= LTW'(l_rnd);
        end
        if (a_rnd < CMIN) begin
            r_a <= CW'(CMIN);
        end else if (a_rnd > CMAX) begin
            r_a <= CW'(CMAX);
        end else begin
            r_a <= CW'(a_rnd);
        end
        if (b_rnd < CMIN) begin
            r_bb <= CW'(CMIN);
        end else if (b_rnd > CMAX) begin
            r_bb <= CW'(CMAX);
        end else begin
            r_bb <= CW'(b_rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= f_v;
            r_v5 <= r_v4;
        end
    end

    assign busy          = 1'b0;
    assign o_strobe      = r_v5;
    assign o_lightness   = r_l;
    assign o_green_red   = r_a;
    assign o_blue_yellow = r_bb;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_strobe) else $error("result missing after item");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT)) else $error("result without item");
    a_l_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_lightness <= LTW'(LMAX))) else $error("lightness out of range");
endmodule
`default_nettype wire
